[rtl/dmts_pkg.sv]
// Shared constants for the deadline-monotonic tick scheduler.
package dmts_pkg;

	// Default sizing of the top level
	localparam int TASKS_DEF       = 4;
	localparam int COUNT_WIDTH_DEF = 16;

	// Fixed field widths
	localparam int REG_W        = 16;
	localparam int TICK_W       = 32;
	localparam int TASK_ID_W    = 2;
	localparam int END_MASK_W   = 4;
	localparam int CFG_INDEX_W  = 3;

	// Register index codes: first register of each bank
	localparam logic [CFG_INDEX_W-1:0] CFG_EXEC_BASE   = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_BASE = 3'd4;

	// Register reset values
	localparam logic [REG_W-1:0] EXEC_RESET   = 16'd0;
	localparam logic [REG_W-1:0] PERIOD_RESET = 16'd1;

endpackage

[rtl/deadline_monotonic_tick_scheduler.sv]
// Deadline-monotonic tick scheduler: one tick or restart word in, one status word out.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+---------------------------------------
//  cfg      | in        | cfg_write                | cfg_index, cfg_data
//  in       | in        | in_valid / in_stall      | restart
//  out      | out       | out_valid / out_stall    | tick_number, task_ran, running_task,
//           |           |                          | period_end_mask, deadline_missed,
//           |           |                          | missed_task, halted
//
// Cycles: one word per cycle while no result waits under out_stall. The whole tick
//   (phase advance, pick, deadline check) is one pass of logic between the schedule state
//   and the result register, so a result shows on out in the cycle after its word is accepted.
// Reset: arst_n clears the schedule state, the result valid, exec times (0) and
//   periods (1). No clearing pass.
// Stalls: in_stall rises only while a result waits under out_stall; a new word is
//   taken in the same cycle the pending result leaves.
module deadline_monotonic_tick_scheduler #(
	parameter int TASKS       = dmts_pkg::TASKS_DEF,
	parameter int COUNT_WIDTH = dmts_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_write,
	input  logic [dmts_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [dmts_pkg::REG_W-1:0]          cfg_data,
	// tick words
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                restart,
	// status words
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [dmts_pkg::TICK_W-1:0]         tick_number,
	output logic                                task_ran,
	output logic [dmts_pkg::TASK_ID_W-1:0]      running_task,
	output logic [dmts_pkg::END_MASK_W-1:0]     period_end_mask,
	output logic                                deadline_missed,
	output logic [dmts_pkg::TASK_ID_W-1:0]      missed_task,
	output logic                                halted
);

	localparam int TaskIdxW = (TASKS > 1) ? $clog2(TASKS) : 1;
	// compare width wide enough for both the counters and the 16-bit registers
	localparam int CmpW = (COUNT_WIDTH > dmts_pkg::REG_W) ? COUNT_WIDTH : dmts_pkg::REG_W;

	// configuration registers
	logic [dmts_pkg::REG_W-1:0] exec_q   [TASKS];
	logic [dmts_pkg::REG_W-1:0] period_q [TASKS];

	// schedule state
	logic [COUNT_WIDTH-1:0]      work_done_q [TASKS];
	logic [COUNT_WIDTH-1:0]      phase_q     [TASKS];
	logic [dmts_pkg::TICK_W-1:0] tick_q;
	logic                        stopped_q;

	// result register
	logic                              out_valid_q;
	logic [dmts_pkg::TICK_W-1:0]       tick_number_q;
	logic                              task_ran_q;
	logic [dmts_pkg::TASK_ID_W-1:0]    running_task_q;
	logic [dmts_pkg::END_MASK_W-1:0]   end_mask_q;
	logic                              missed_q;
	logic [dmts_pkg::TASK_ID_W-1:0]    missed_task_q;
	logic                              halted_q;

	// tick logic
	logic                   in_accept;
	logic                   cfg_period_bank;
	logic [TaskIdxW-1:0]    cfg_slot;
	logic [COUNT_WIDTH-1:0] phase_inc [TASKS];
	logic [TASKS-1:0]       end_vec;
	logic                   run_found;
	logic [TaskIdxW-1:0]    run_idx;
	logic [COUNT_WIDTH-1:0] wd_run    [TASKS];
	logic                   miss_found;
	logic [TaskIdxW-1:0]    miss_idx;
	logic [TASKS-1:0]       clear_vec;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = out_valid_q && out_stall;

	// ---------------------------------------------------------------- config
	assign cfg_period_bank = (cfg_index >= dmts_pkg::CFG_PERIOD_BASE);
	assign cfg_slot = cfg_period_bank ? TaskIdxW'(cfg_index - dmts_pkg::CFG_PERIOD_BASE)
	                                  : TaskIdxW'(cfg_index - dmts_pkg::CFG_EXEC_BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < TASKS; j++) begin
				exec_q[j]   <= dmts_pkg::EXEC_RESET;
				period_q[j] <= dmts_pkg::PERIOD_RESET;
			end
		end else if (cfg_write) begin
			// slots beyond the task count land nowhere
			for (int j = 0; j < TASKS; j++) begin
				if (cfg_slot == TaskIdxW'(j) &&
				    2'(cfg_index - (cfg_period_bank ? dmts_pkg::CFG_PERIOD_BASE
				                                    : dmts_pkg::CFG_EXEC_BASE)) == 2'(j)) begin
					if (cfg_period_bank) begin
						period_q[j] <= cfg_data;
					end else begin
						exec_q[j] <= cfg_data;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- tick
	// Advance every phase counter; a period ends when the next phase reaches
	// the period or the counter wraps (period zero ends every tick).
	always_comb begin
		for (int j = 0; j < TASKS; j++) begin
			phase_inc[j] = phase_q[j] + 1'b1;
			end_vec[j]   = (CmpW'(phase_inc[j]) >= CmpW'(period_q[j])) ||
			               (phase_inc[j] == '0);
		end
	end

	// Pick the task with work left and the shortest period; scanning in index
	// order keeps the lower index on a tie.
	always_comb begin
		run_found = 1'b0;
		run_idx   = '0;
		for (int j = 0; j < TASKS; j++) begin
			if (CmpW'(work_done_q[j]) < CmpW'(exec_q[j]) &&
			    (!run_found || period_q[j] < period_q[run_idx])) begin
				run_found = 1'b1;
				run_idx   = TaskIdxW'(j);
			end
		end
	end

	// Credit the running task with one unit of work.
	always_comb begin
		for (int j = 0; j < TASKS; j++) begin
			wd_run[j] = (run_found && run_idx == TaskIdxW'(j)) ? work_done_q[j] + 1'b1
			                                                     : work_done_q[j];
		end
	end

	// First miss in priority order among tasks whose period just ended.
	always_comb begin
		miss_found = 1'b0;
		miss_idx   = '0;
		for (int j = 0; j < TASKS; j++) begin
			if (end_vec[j] && CmpW'(wd_run[j]) < CmpW'(exec_q[j]) &&
			    (!miss_found || period_q[j] < period_q[miss_idx])) begin
				miss_found = 1'b1;
				miss_idx   = TaskIdxW'(j);
			end
		end
	end

	// Clear finished periods, but only for tasks ahead of the missing one.
	always_comb begin
		for (int j = 0; j < TASKS; j++) begin
			clear_vec[j] = end_vec[j] &&
			               (!miss_found ||
			                period_q[j] < period_q[miss_idx] ||
			                (period_q[j] == period_q[miss_idx] &&
			                 TaskIdxW'(j) < miss_idx));
		end
	end

	// Schedule state: update only on an accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < TASKS; j++) begin
				work_done_q[j] <= '0;
				phase_q[j]     <= '0;
			end
			tick_q    <= '0;
			stopped_q <= 1'b0;
		end else if (in_accept) begin
			if (restart) begin
				for (int j = 0; j < TASKS; j++) begin
					work_done_q[j] <= '0;
					phase_q[j]     <= '0;
				end
				tick_q    <= '0;
				stopped_q <= 1'b0;
			end else if (!stopped_q) begin
				for (int j = 0; j < TASKS; j++) begin
					phase_q[j]     <= end_vec[j] ? '0 : phase_inc[j];
					work_done_q[j] <= clear_vec[j] ? '0 : wd_run[j];
				end
				tick_q    <= tick_q + 1'b1;
				stopped_q <= miss_found;
			end
		end
	end

	// ---------------------------------------------------------------- result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			if (restart) begin
				// restart reports all zero
				tick_number_q  <= '0;
				task_ran_q     <= 1'b0;
				running_task_q <= '0;
				end_mask_q     <= '0;
				missed_q       <= 1'b0;
				missed_task_q  <= '0;
				halted_q       <= 1'b0;
			end else if (stopped_q) begin
				// hold: repeat the frozen tick and flag halted
				tick_number_q  <= tick_q;
				task_ran_q     <= 1'b0;
				running_task_q <= '0;
				end_mask_q     <= '0;
				missed_q       <= 1'b0;
				missed_task_q  <= '0;
				halted_q       <= 1'b1;
			end else begin
				tick_number_q  <= tick_q + 1'b1;
				task_ran_q     <= run_found;
				running_task_q <= dmts_pkg::TASK_ID_W'(run_idx);
				end_mask_q     <= dmts_pkg::END_MASK_W'(end_vec);
				missed_q       <= miss_found;
				missed_task_q  <= dmts_pkg::TASK_ID_W'(miss_idx);
				halted_q       <= miss_found;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign tick_number     = tick_number_q;
	assign task_ran        = task_ran_q;
	assign running_task    = running_task_q;
	assign period_end_mask = end_mask_q;
	assign deadline_missed = missed_q;
	assign missed_task     = missed_task_q;
	assign halted          = halted_q;

endmodule

[rtl/dmts_checker.sv]
// Port-level checks for the deadline-monotonic tick scheduler, bound to the top level.
module dmts_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_write,
	input logic [dmts_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input logic [dmts_pkg::REG_W-1:0]        cfg_data,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic                              restart,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [dmts_pkg::TICK_W-1:0]       tick_number,
	input logic                              task_ran,
	input logic [dmts_pkg::TASK_ID_W-1:0]    running_task,
	input logic [dmts_pkg::END_MASK_W-1:0]   period_end_mask,
	input logic                              deadline_missed,
	input logic [dmts_pkg::TASK_ID_W-1:0]    missed_task,
	input logic                              halted
);

	// every accepted word yields a result in the next cycle
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted word produced no result");

	// restart reports a cleared schedule
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && restart) |=>
		(tick_number == '0 && !halted && !task_ran && period_end_mask == '0))
		else $error("restart result not cleared");

	// a miss always stops the schedule
	a_miss_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && deadline_missed) |-> halted)
		else $error("deadline miss without halt");

	// once halted, no task runs and no period ends
	a_halted_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && halted && !deadline_missed) |->
		(!task_ran && period_end_mask == '0 && running_task == '0 && missed_task == '0))
		else $error("activity reported while halted");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(tick_number) && $stable(halted)))
		else $error("stalled result changed");

endmodule

bind deadline_monotonic_tick_scheduler dmts_checker u_dmts_checker (.*);

[tb/tb_deadline_monotonic_tick_scheduler.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the deadline-monotonic tick scheduler.
module tb_deadline_monotonic_tick_scheduler;

	localparam int NTASK       = dmts_pkg::TASKS_DEF;
	localparam int CW          = dmts_pkg::COUNT_WIDTH_DEF;
	localparam int SLOT_W      = (NTASK > 1) ? $clog2(NTASK) : 1;
	localparam int CYCLE_LIMIT = 200000;

	// One status word as the scheduler should report it
	typedef struct packed {
		logic [dmts_pkg::TICK_W-1:0]     tick;
		logic                            ran;
		logic [dmts_pkg::TASK_ID_W-1:0]  ran_id;
		logic [dmts_pkg::END_MASK_W-1:0] ends;
		logic                            missed;
		logic [dmts_pkg::TASK_ID_W-1:0]  miss_id;
		logic                            halted;
	} status_word_t;

	// Block ports; every input starts at a known value
	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             cfg_write = 1'b0;
	logic [dmts_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [dmts_pkg::REG_W-1:0]       cfg_data  = '0;
	logic                             in_valid  = 1'b0;
	logic                             in_stall;
	logic                             restart   = 1'b0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [dmts_pkg::TICK_W-1:0]      tick_number;
	logic                             task_ran;
	logic [dmts_pkg::TASK_ID_W-1:0]   running_task;
	logic [dmts_pkg::END_MASK_W-1:0]  period_end_mask;
	logic                             deadline_missed;
	logic [dmts_pkg::TASK_ID_W-1:0]   missed_task;
	logic                             halted;

	// Shadow of the register file and the schedule state
	logic [dmts_pkg::REG_W-1:0]  exec_reg   [NTASK];
	logic [dmts_pkg::REG_W-1:0]  period_reg [NTASK];
	logic [CW-1:0]               done_cnt   [NTASK];
	logic [CW-1:0]               phase_cnt  [NTASK];
	logic [dmts_pkg::TICK_W-1:0] tick_cnt;
	logic                        sched_halted;

	// Words waiting to be sent, status words waiting to arrive
	logic         tick_queue [$];
	status_word_t status_due [$];

	// Idling controls, set per phase by the stimulus
	logic tx_idle = 1'b1;
	logic rx_idle = 1'b1;
	int   tx_wait = 0;
	int   rx_wait = 0;

	// Bookkeeping
	int errors       = 0;
	int cycle_count  = 0;
	int words_sent   = 0;
	int words_seen   = 0;
	int reg_writes   = 0;
	int restarts     = 0;
	int misses       = 0;
	int halted_ticks = 0;

	deadline_monotonic_tick_scheduler i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.restart         (restart),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.tick_number     (tick_number),
		.task_ran        (task_ran),
		.running_task    (running_task),
		.period_end_mask (period_end_mask),
		.deadline_missed (deadline_missed),
		.missed_task     (missed_task),
		.halted          (halted)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Shorter period wins; equal periods go to the lower index. Period zero
	// naturally sorts ahead of everything in an unsigned compare.
	function automatic logic outranks(input int a, input int b);
		if (period_reg[a] != period_reg[b])
			return period_reg[a] < period_reg[b];
		return a < b;
	endfunction

	// Advance the shadow schedule by one word and return the status it yields
	function automatic status_word_t schedule_tick(input logic rst);
		status_word_t w;
		int           run_id;
		int           miss_id;
		logic [CW-1:0] nxt;
		w       = '0;
		run_id  = -1;
		miss_id = -1;
		if (rst) begin
			// Restart wipes the schedule but keeps the registers
			for (int j = 0; j < NTASK; j++) begin
				done_cnt[j]  = '0;
				phase_cnt[j] = '0;
			end
			tick_cnt     = '0;
			sched_halted = 1'b0;
			restarts++;
			return w;
		end
		if (sched_halted) begin
			// Frozen: repeat the tick count, flag the halt, nothing else
			w.tick   = tick_cnt;
			w.halted = 1'b1;
			halted_ticks++;
			return w;
		end
		tick_cnt = tick_cnt + 1'b1;
		// Advance phases; a phase at or past the period (lowered period,
		// period zero) closes the period on this tick
		for (int j = 0; j < NTASK; j++) begin
			nxt = phase_cnt[j] + 1'b1;
			if (nxt >= period_reg[j] || nxt == '0) begin
				w.ends[j]    = 1'b1;
				phase_cnt[j] = '0;
			end else begin
				phase_cnt[j] = nxt;
			end
		end
		// Run the best-ranked task that still has work
		for (int j = 0; j < NTASK; j++)
			if (done_cnt[j] < exec_reg[j] && (run_id < 0 || outranks(j, run_id)))
				run_id = j;
		if (run_id >= 0)
			done_cnt[run_id] = done_cnt[run_id] + 1'b1;
		// Deadline check: the best-ranked unfinished task at its period end.
		// A task whose exec time dropped below its done count counts as finished.
		for (int j = 0; j < NTASK; j++)
			if (w.ends[j] && done_cnt[j] < exec_reg[j] &&
			    (miss_id < 0 || outranks(j, miss_id)))
				miss_id = j;
		// Clear finished periods ahead of the miss; those behind keep their counts
		for (int j = 0; j < NTASK; j++)
			if (w.ends[j] && (miss_id < 0 || outranks(j, miss_id)))
				done_cnt[j] = '0;
		if (miss_id >= 0) begin
			sched_halted = 1'b1;
			misses++;
		end
		w.tick    = tick_cnt;
		w.ran     = run_id >= 0;
		w.ran_id  = run_id >= 0 ? run_id[dmts_pkg::TASK_ID_W-1:0] : '0;
		w.missed  = miss_id >= 0;
		w.miss_id = miss_id >= 0 ? miss_id[dmts_pkg::TASK_ID_W-1:0] : '0;
		w.halted  = sched_halted;
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
	                               input logic [31:0] want);
		errors++;
		$display("[%0t] MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
	endtask

	// Driver: take the accepted word into the prediction, then load the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				status_due.push_back(schedule_tick(restart));
				words_sent++;
			end
			// Hold a stalled word; otherwise idle out the gap or present the next
			if (!in_valid || !in_stall) begin
				if (tx_wait > 0) begin
					tx_wait--;
					in_valid <= 1'b0;
				end else if (tick_queue.size() > 0) begin
					in_valid <= 1'b1;
					restart  <= tick_queue.pop_front();
					tx_wait  = tx_idle ? $urandom_range(0, 9) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted status word against the oldest prediction
	always @(posedge clk) begin
		status_word_t w;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				words_seen++;
				if (status_due.size() == 0) begin
					report_mismatch("status word with nothing pending, tick_number",
					                tick_number, '0);
				end else begin
					w = status_due.pop_front();
					if (tick_number !== w.tick)
						report_mismatch("tick_number", tick_number, w.tick);
					if (task_ran !== w.ran)
						report_mismatch("task_ran", 32'(task_ran), 32'(w.ran));
					if (running_task !== w.ran_id)
						report_mismatch("running_task", 32'(running_task), 32'(w.ran_id));
					if (period_end_mask !== w.ends)
						report_mismatch("period_end_mask", 32'(period_end_mask),
						                32'(w.ends));
					if (deadline_missed !== w.missed)
						report_mismatch("deadline_missed", 32'(deadline_missed),
						                32'(w.missed));
					if (missed_task !== w.miss_id)
						report_mismatch("missed_task", 32'(missed_task), 32'(w.miss_id));
					if (halted !== w.halted)
						report_mismatch("halted", 32'(halted), 32'(w.halted));
				end
				rx_wait = rx_idle ? $urandom_range(0, 9) : 0;
			end
			// Stall the next status word for the drawn number of cycles
			if (rx_wait > 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[%0t] timeout: %0d status words still pending", $realtime,
			         status_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic queue_ticks(input int count);
		repeat (count) tick_queue.push_back(1'b0);
	endtask

	// Wait until nothing is queued, in flight or owed by the block
	task automatic wait_idle();
		@(posedge clk);
		while (tick_queue.size() != 0 || in_valid || status_due.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Drive one register write; the shadow copy changes with it since the
	// block is idle and no word can observe the gap
	task automatic set_reg(input int idx, input int val);
		logic [SLOT_W-1:0] slot;
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= dmts_pkg::CFG_INDEX_W'(idx);
		cfg_data  <= dmts_pkg::REG_W'(val);
		if (idx >= dmts_pkg::CFG_PERIOD_BASE) begin
			slot             = SLOT_W'(idx - dmts_pkg::CFG_PERIOD_BASE);
			period_reg[slot] = dmts_pkg::REG_W'(val);
		end else begin
			slot           = SLOT_W'(idx - dmts_pkg::CFG_EXEC_BASE);
			exec_reg[slot] = dmts_pkg::REG_W'(val);
		end
		reg_writes++;
	endtask

	task automatic close_writes();
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		int per;
		int mode;
		for (int j = 0; j < NTASK; j++) begin
			exec_reg[j]   = dmts_pkg::EXEC_RESET;
			period_reg[j] = dmts_pkg::PERIOD_RESET;
			done_cnt[j]   = '0;
			phase_cnt[j]  = '0;
		end
		tick_cnt     = '0;
		sched_halted = 1'b0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset registers, every task idle, every period ends each tick
		queue_ticks(1);
		wait_idle();

		// Period zero outranks all; its hog starves task 1 into a miss, the
		// tasks ahead of the miss get cleared, then the block sits halted
		set_reg(dmts_pkg::CFG_EXEC_BASE + 0, 2);
		set_reg(dmts_pkg::CFG_PERIOD_BASE + 0, 4);
		set_reg(dmts_pkg::CFG_EXEC_BASE + 1, 1);
		set_reg(dmts_pkg::CFG_PERIOD_BASE + 1, 2);
		set_reg(dmts_pkg::CFG_EXEC_BASE + 2, 0);
		set_reg(dmts_pkg::CFG_PERIOD_BASE + 2, 0);
		set_reg(dmts_pkg::CFG_EXEC_BASE + 3, 1);
		set_reg(dmts_pkg::CFG_PERIOD_BASE + 3, 0);
		close_writes();
		queue_ticks(4);
		tick_queue.push_back(1'b1);
		wait_idle();

		// Part way through a long period, drop the period below the phase and
		// the exec time below the work already done: the period closes cleanly
		set_reg(dmts_pkg::CFG_EXEC_BASE + 3, 0);
		set_reg(dmts_pkg::CFG_PERIOD_BASE + 3, 'hFFFF);
		set_reg(dmts_pkg::CFG_EXEC_BASE + 1, 0);
		set_reg(dmts_pkg::CFG_EXEC_BASE + 0, 5);
		set_reg(dmts_pkg::CFG_PERIOD_BASE + 0, 8);
		close_writes();
		queue_ticks(3);
		wait_idle();
		set_reg(dmts_pkg::CFG_PERIOD_BASE + 0, 2);
		set_reg(dmts_pkg::CFG_EXEC_BASE + 0, 1);
		close_writes();
		queue_ticks(2);
		wait_idle();

		// Full-scale registers and a four-way tie on period; then a period
		// of one pulls task 2 ahead and it misses straight away
		for (int j = 0; j < NTASK; j++) begin
			set_reg(dmts_pkg::CFG_EXEC_BASE + j, 'hFFFF);
			set_reg(dmts_pkg::CFG_PERIOD_BASE + j, 'hFFFF);
		end
		close_writes();
		tick_queue.push_back(1'b1);
		queue_ticks(3);
		wait_idle();
		set_reg(dmts_pkg::CFG_PERIOD_BASE + 2, 1);
		close_writes();
		queue_ticks(2);
		tick_queue.push_back(1'b1);
		wait_idle();

		// Random phases; each ends with a full drain so the sender pauses
		// until every status word is back before the registers change
		for (int p = 0; p < 8; p++) begin
			mode    = $urandom_range(0, 3);
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			if (mode == 0) begin
				// Anything the registers hold
				for (int j = 0; j < 2 * NTASK; j++)
					set_reg(j, $urandom_range(0, 'hFFFF));
				close_writes();
			end else if (mode != 3 || p == 0) begin
				// Short periods and light loads that survive for a while
				for (int j = 0; j < NTASK; j++) begin
					per = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 16);
					set_reg(dmts_pkg::CFG_PERIOD_BASE + j, per);
					set_reg(dmts_pkg::CFG_EXEC_BASE + j, ($urandom_range(0, 3) == 0) ? 0 :
					        $urandom_range(1, per / 4 + 1));
				end
				close_writes();
			end
			// Keep the old schedule running now and then to catch register
			// changes in mid-period
			if ($urandom_range(0, 1) != 0)
				tick_queue.push_back(1'b1);
			for (int n = 0; n < 50; n++)
				tick_queue.push_back($urandom_range(0, 15) == 0);
			wait_idle();
		end

		repeat (4) @(posedge clk);
		if (status_due.size() != 0)
			report_mismatch("status words never delivered", 32'(status_due.size()), 32'd0);

		$display("Covered %0d words (%0d restarts, %0d deadline misses, %0d halted ticks)",
		         words_sent, restarts, misses, halted_ticks);
		$display("%0d status words checked after %0d register writes in %0d cycles",
		         words_seen, reg_writes, cycle_count);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
